>>> src/tgc_pkg.sv
// shared types and constants for the touch gesture classifier
`default_nettype none

package tgc_pkg;

  localparam int TimeW  = 32;
  localparam int MsW    = 16;
  localparam int SwipeW = 12;
  localparam int CfgIdxW = 3;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvClick = 2'd1,
    EvHold  = 2'd2,
    EvSwipe = 2'd3
  } event_e;

  typedef enum logic {
    OpSample = 1'b0,
    OpPoll   = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgReleaseTimeout = 3'd0,
    CfgClickMax       = 3'd1,
    CfgClickMin       = 3'd2,
    CfgHold           = 3'd3,
    CfgSwipePx        = 3'd4
  } cfg_idx_e;

  localparam logic [MsW-1:0]    RstReleaseTimeout = 16'd100;
  localparam logic [MsW-1:0]    RstClickMax       = 16'd500;
  localparam logic [MsW-1:0]    RstClickMin       = 16'd20;
  localparam logic [MsW-1:0]    RstHold           = 16'd700;
  localparam logic [SwipeW-1:0] RstSwipePx        = 12'd50;

  typedef struct packed {
    logic [MsW-1:0]    release_timeout;
    logic [MsW-1:0]    click_max;
    logic [MsW-1:0]    click_min;
    logic [MsW-1:0]    hold;
    logic [SwipeW-1:0] swipe_px;
  } cfg_t;

endpackage

`default_nettype wire

>>> src/touch_gesture_classifier.sv
// top level: input register, gesture rules and result register
`default_nettype none

// Takes one sample or poll per clock while in_stall_o is low and returns exactly
// one result per item: the transfer lands in the input register, then the
// gesture rules update the touch state and load the result register once it
// is free. Since the state is read and written in that single stage, items
// stream back to back at one per cycle; throughput drops only while the
// consumer holds out_stall_i. Thresholds are written through the cfg port,
// which is always ready, and should only change while no item is in flight.
module touch_gesture_classifier
  import tgc_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [MsW-1:0]          cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    op_i,
  input  wire logic [TimeW-1:0]        now_ms_i,
  input  wire logic [COORD_BITS-1:0]   x_pos_i,
  input  wire logic [COORD_BITS-1:0]   y_pos_i,
  input  wire logic                    swipe_accept_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [1:0]                   event_res_o,
  output logic [COORD_BITS-1:0]        pos_x_o,
  output logic [COORD_BITS-1:0]        pos_y_o,
  output logic signed [COORD_BITS:0]   delta_x_o,
  output logic signed [COORD_BITS:0]   delta_y_o
);

  cfg_t cfg;

  logic                  s1_valid_q;
  logic                  s1_op_q;
  logic [TimeW-1:0]      s1_now_q;
  logic [COORD_BITS-1:0] s1_x_q, s1_y_q;
  logic                  s1_acc_q;

  logic                  out_valid_q;
  event_e                ev_q;
  logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic [COORD_BITS:0]   dx_q, dy_q;

  event_e                ev;
  logic [COORD_BITS-1:0] pos_x, pos_y;
  logic [COORD_BITS:0]   dx, dy;
  logic                  out_free, s1_adv, s1_load;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign s1_load    = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !out_free;

  tgc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tgc_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .proc_i    (s1_adv),
    .op_i      (s1_op_q),
    .now_i     (s1_now_q),
    .x_i       (s1_x_q),
    .y_i       (s1_y_q),
    .accept_i  (s1_acc_q),
    .cfg_i     (cfg),
    .event_o   (ev),
    .pos_x_o   (pos_x),
    .pos_y_o   (pos_y),
    .delta_x_o (dx),
    .delta_y_o (dy)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_op_q  <= op_i;
      s1_now_q <= now_ms_i;
      s1_x_q   <= x_pos_i;
      s1_y_q   <= y_pos_i;
      s1_acc_q <= swipe_accept_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ev_q    <= ev;
      pos_x_q <= pos_x;
      pos_y_q <= pos_y;
      dx_q    <= dx;
      dy_q    <= dy;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = ev_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign delta_x_o   = $signed(dx_q);
  assign delta_y_o   = $signed(dy_q);

endmodule

`default_nettype wire

>>> src/tgc_cfg.sv
// configuration register file for the gesture thresholds
`default_nettype none

module tgc_cfg
  import tgc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [MsW-1:0]     cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.release_timeout <= RstReleaseTimeout;
      cfg_q.click_max       <= RstClickMax;
      cfg_q.click_min       <= RstClickMin;
      cfg_q.hold            <= RstHold;
      cfg_q.swipe_px        <= RstSwipePx;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgReleaseTimeout: cfg_q.release_timeout <= cfg_data_i;
        CfgClickMax:       cfg_q.click_max       <= cfg_data_i;
        CfgClickMin:       cfg_q.click_min       <= cfg_data_i;
        CfgHold:           cfg_q.hold            <= cfg_data_i;
        CfgSwipePx:        cfg_q.swipe_px        <= cfg_data_i[SwipeW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/tgc_core.sv
// touch state and gesture rules, evaluated once per item
`default_nettype none

module tgc_core
  import tgc_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  proc_i,
  input  wire logic                  op_i,
  input  wire logic [TimeW-1:0]      now_i,
  input  wire logic [COORD_BITS-1:0] x_i,
  input  wire logic [COORD_BITS-1:0] y_i,
  input  wire logic                  accept_i,
  input  wire cfg_t                  cfg_i,
  output event_e                     event_o,
  output logic [COORD_BITS-1:0]      pos_x_o,
  output logic [COORD_BITS-1:0]      pos_y_o,
  output logic [COORD_BITS:0]        delta_x_o,
  output logic [COORD_BITS:0]        delta_y_o
);

  localparam int CmpW = (COORD_BITS > SwipeW) ? COORD_BITS : SwipeW;

  logic                  contact_q, contact_d;
  logic                  hold_rep_q, hold_rep_d;
  logic                  latched_q, latched_d;
  logic [TimeW-1:0]      start_t_q, start_t_d;
  logic [TimeW-1:0]      last_t_q, last_t_d;
  logic [COORD_BITS-1:0] start_x_q, start_x_d;
  logic [COORD_BITS-1:0] start_y_q, start_y_d;
  logic [COORD_BITS-1:0] end_x_q, end_x_d;
  logic [COORD_BITS-1:0] end_y_q, end_y_d;

  logic [TimeW-1:0]      gap, dur, tmo;
  logic                  released, live, is_click, is_hold, moved;
  logic [COORD_BITS-1:0] abs_x, abs_y;
  logic [COORD_BITS:0]   dx, dy;

  assign gap      = now_i - last_t_q;
  assign dur      = last_t_q - start_t_q;
  assign tmo      = TimeW'(cfg_i.release_timeout);
  assign released = gap > tmo;
  assign live     = gap < tmo;
  assign is_click = !latched_q && released && (dur <= TimeW'(cfg_i.click_max))
                    && (dur >= TimeW'(cfg_i.click_min));
  assign is_hold  = !hold_rep_q && !latched_q && live && (dur >= TimeW'(cfg_i.hold));

  assign abs_x = (end_x_q >= start_x_q) ? end_x_q - start_x_q : start_x_q - end_x_q;
  assign abs_y = (end_y_q >= start_y_q) ? end_y_q - start_y_q : start_y_q - end_y_q;
  assign moved = latched_q || (CmpW'(abs_x) > CmpW'(cfg_i.swipe_px))
                 || (CmpW'(abs_y) > CmpW'(cfg_i.swipe_px));
  assign dx    = {1'b0, end_x_q} - {1'b0, start_x_q};
  assign dy    = {1'b0, end_y_q} - {1'b0, start_y_q};

  always_comb begin
    contact_d = contact_q;
    hold_rep_d = hold_rep_q;
    latched_d = latched_q;
    start_t_d = start_t_q;
    last_t_d  = last_t_q;
    start_x_d = start_x_q;
    start_y_d = start_y_q;
    end_x_d   = end_x_q;
    end_y_d   = end_y_q;
    event_o   = EvNone;
    pos_x_o   = '0;
    pos_y_o   = '0;
    delta_x_o = '0;
    delta_y_o = '0;
    if (op_i == OpSample) begin
      end_x_d  = x_i;
      end_y_d  = y_i;
      last_t_d = now_i;
      if (!contact_q) begin
        contact_d = 1'b1;
        start_t_d = now_i;
        start_x_d = x_i;
        start_y_d = y_i;
      end
    end else if (contact_q) begin
      if (is_click) begin
        event_o   = EvClick;
        pos_x_o   = end_x_q;
        pos_y_o   = end_y_q;
        contact_d = 1'b0;
      end else if (is_hold) begin
        event_o    = EvHold;
        pos_x_o    = end_x_q;
        pos_y_o    = end_y_q;
        hold_rep_d = 1'b1;
      end else if (live) begin
        if (moved) begin
          event_o   = EvSwipe;
          pos_x_o   = start_x_q;
          pos_y_o   = start_y_q;
          delta_x_o = dx;
          delta_y_o = dy;
          if (accept_i) begin
            start_x_d = end_x_q;
            start_y_d = end_y_q;
            latched_d = 1'b1;
          end
        end
      end else if (released) begin
        contact_d  = 1'b0;
        hold_rep_d = 1'b0;
        latched_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contact_q  <= 1'b0;
      hold_rep_q <= 1'b0;
      latched_q  <= 1'b0;
      start_t_q  <= '0;
      last_t_q   <= '0;
      start_x_q  <= '0;
      start_y_q  <= '0;
      end_x_q    <= '0;
      end_y_q    <= '0;
    end else if (proc_i) begin
      contact_q  <= contact_d;
      hold_rep_q <= hold_rep_d;
      latched_q  <= latched_d;
      start_t_q  <= start_t_d;
      last_t_q   <= last_t_d;
      start_x_q  <= start_x_d;
      start_y_q  <= start_y_d;
      end_x_q    <= end_x_d;
      end_y_q    <= end_y_d;
    end
  end

  a_hold_sets_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && event_o == EvHold |=> hold_rep_q)
    else $error("hold reported without setting the hold flag");

  a_click_ends_touch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && event_o == EvClick |=> !contact_q)
    else $error("touch still active after click");

  a_sample_opens : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && op_i == OpSample |=> contact_q && last_t_q == $past(now_i))
    else $error("sample did not open or refresh the touch");

  a_idle_no_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !contact_q |-> event_o == EvNone)
    else $error("event without an active touch");

endmodule

`default_nettype wire

>>> test/touch_gesture_classifier_test.sv
// testbench for the touch gesture classifier: random touch streams checked against a predictor
module touch_gesture_classifier_test
  import tgc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CoordW   = 12;
  localparam int MaxCoord = (1 << CoordW) - 1;
  localparam int LongHold = 150;

  typedef struct {
    op_e               op;
    logic [TimeW-1:0]  now;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              accept;
  } touch_t;

  typedef struct {
    event_e                   ev;
    logic [CoordW-1:0]        px;
    logic [CoordW-1:0]        py;
    logic signed [CoordW:0]   dx;
    logic signed [CoordW:0]   dy;
  } gesture_t;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic [MsW-1:0]           cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     op_i = 1'b0;
  logic [TimeW-1:0]         now_ms_i = '0;
  logic [CoordW-1:0]        x_pos_i = '0;
  logic [CoordW-1:0]        y_pos_i = '0;
  logic                     swipe_accept_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [1:0]               event_res_o;
  logic [CoordW-1:0]        pos_x_o;
  logic [CoordW-1:0]        pos_y_o;
  logic signed [CoordW:0]   delta_x_o;
  logic signed [CoordW:0]   delta_y_o;

  touch_gesture_classifier #(
    .COORD_BITS(CoordW)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .now_ms_i      (now_ms_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .swipe_accept_i(swipe_accept_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_res_o   (event_res_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .delta_x_o     (delta_x_o),
    .delta_y_o     (delta_y_o)
  );

  // touch tracking state of the predictor
  cfg_t              limits;
  logic              touch_open = 1'b0;
  logic              hold_done = 1'b0;
  logic              swipe_locked = 1'b0;
  logic [TimeW-1:0]  t_start = '0;
  logic [TimeW-1:0]  t_last = '0;
  logic [CoordW-1:0] x_start = '0;
  logic [CoordW-1:0] y_start = '0;
  logic [CoordW-1:0] x_end = '0;
  logic [CoordW-1:0] y_end = '0;

  touch_t     touch_queue[$];
  gesture_t   gesture_queue[$];
  touch_t     cur_touch;
  logic [TimeW-1:0] t_ms;
  int         phase_items;
  int         send_gap_max = 0;
  int         recv_wait_max = 0;
  int         send_wait = 0;
  int         stall_left = 0;
  int         long_hold_req = 0;
  int         hold_seen = 0;
  int         error_count = 0;
  int         results_checked = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic gesture_t classify_touch(input touch_t it);
    gesture_t          r;
    logic [TimeW-1:0]  gap;
    logic [TimeW-1:0]  dur;
    logic              released;
    logic              live;
    logic [CoordW-1:0] adx;
    logic [CoordW-1:0] ady;
    r.ev = EvNone;
    r.px = '0;
    r.py = '0;
    r.dx = '0;
    r.dy = '0;
    if (it.op == OpSample) begin
      x_end = it.x;
      y_end = it.y;
      t_last = it.now;
      if (!touch_open) begin
        touch_open = 1'b1;
        t_start = it.now;
        x_start = it.x;
        y_start = it.y;
      end
    end else if (touch_open) begin
      gap = it.now - t_last;
      dur = t_last - t_start;
      released = gap > TimeW'(limits.release_timeout);
      live = gap < TimeW'(limits.release_timeout);
      adx = (x_end >= x_start) ? x_end - x_start : x_start - x_end;
      ady = (y_end >= y_start) ? y_end - y_start : y_start - y_end;
      if (!swipe_locked && released && dur <= TimeW'(limits.click_max) &&
          dur >= TimeW'(limits.click_min)) begin
        r.ev = EvClick;
        r.px = x_end;
        r.py = y_end;
        touch_open = 1'b0;
      end else if (!hold_done && !swipe_locked && live && dur >= TimeW'(limits.hold)) begin
        hold_done = 1'b1;
        r.ev = EvHold;
        r.px = x_end;
        r.py = y_end;
      end else if (live) begin
        if (swipe_locked || adx > limits.swipe_px || ady > limits.swipe_px) begin
          r.ev = EvSwipe;
          r.px = x_start;
          r.py = y_start;
          r.dx = {1'b0, x_end} - {1'b0, x_start};
          r.dy = {1'b0, y_end} - {1'b0, y_start};
          if (it.accept) begin
            x_start = x_end;
            y_start = y_end;
            swipe_locked = 1'b1;
          end
        end
      end else if (released) begin
        touch_open = 1'b0;
        hold_done = 1'b0;
        swipe_locked = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic int draw_wait(input int max_wait);
    if (max_wait == 0) return 0;
    case ($urandom_range(0, 3))
      0, 1: return 0;
      2: return $urandom_range(1, 3);
      default: return $urandom_range(0, max_wait);
    endcase
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > MaxCoord) return MaxCoord;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 100) $display("mismatch on result %0d: %s", results_checked, msg);
  endtask

  // sender: one transfer per item, random gap after each
  always @(posedge clk_i or negedge rst_ni) begin : drive_touch
    touch_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) gesture_queue.push_back(classify_touch(cur_touch));
      if (!in_valid_i || !in_stall_o) begin
        if (send_wait != 0) begin
          in_valid_i <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (touch_queue.size() != 0) begin
          nxt = touch_queue.pop_front();
          cur_touch <= nxt;
          op_i <= nxt.op;
          now_ms_i <= nxt.now;
          x_pos_i <= nxt.x;
          y_pos_i <= nxt.y;
          swipe_accept_i <= nxt.accept;
          in_valid_i <= 1'b1;
          send_wait <= draw_wait(send_gap_max);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall: random wait after each transfer, long hold on request
  always @(posedge clk_i or negedge rst_ni) begin : stall_results
    int w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != long_hold_req) begin
      hold_seen <= long_hold_req;
      out_stall_i <= 1'b1;
      stall_left <= LongHold;
    end else if (out_valid_o && !out_stall_i) begin
      w = draw_wait(recv_wait_max);
      out_stall_i <= (w != 0);
      stall_left <= (w != 0) ? w - 1 : 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_gesture
    gesture_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (gesture_queue.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = gesture_queue.pop_front();
        if (event_res_o !== want.ev)
          report_mismatch($sformatf("event %0d, want %0d", event_res_o, want.ev));
        if (pos_x_o !== want.px)
          report_mismatch($sformatf("pos_x %0d, want %0d", pos_x_o, want.px));
        if (pos_y_o !== want.py)
          report_mismatch($sformatf("pos_y %0d, want %0d", pos_y_o, want.py));
        if (delta_x_o !== want.dx)
          report_mismatch($sformatf("delta_x %0d, want %0d", delta_x_o, want.dx));
        if (delta_y_o !== want.dy)
          report_mismatch($sformatf("delta_y %0d, want %0d", delta_y_o, want.dy));
      end
    end
  end

  task automatic push_sample(input logic [TimeW-1:0] now, input int x, input int y);
    touch_t it;
    it.op = OpSample;
    it.now = now;
    it.x = CoordW'(x);
    it.y = CoordW'(y);
    it.accept = 1'($urandom_range(0, 1));
    touch_queue.push_back(it);
    t_ms = now;
    phase_items++;
  endtask

  task automatic push_poll(input logic [TimeW-1:0] now, input logic accept);
    touch_t it;
    it.op = OpPoll;
    it.now = now;
    it.x = CoordW'($urandom);
    it.y = CoordW'($urandom);
    it.accept = accept;
    touch_queue.push_back(it);
    t_ms = now;
    phase_items++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (touch_queue.size() != 0 || in_valid_i || gesture_queue.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [MsW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(negedge clk_i);
    while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgReleaseTimeout: limits.release_timeout = data;
      CfgClickMax:       limits.click_max = data;
      CfgClickMin:       limits.click_min = data;
      CfgHold:           limits.hold = data;
      CfgSwipePx:        limits.swipe_px = data[SwipeW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic write_all(input logic [MsW-1:0] tmo, input logic [MsW-1:0] cmax,
                           input logic [MsW-1:0] cmin, input logic [MsW-1:0] hold,
                           input logic [MsW-1:0] swipe);
    write_reg(CfgReleaseTimeout, tmo);
    write_reg(CfgClickMax, cmax);
    write_reg(CfgClickMin, cmin);
    write_reg(CfgHold, hold);
    write_reg(CfgSwipePx, swipe);
  endtask

  // one touch from first contact to release, shaped by the current thresholds
  task automatic gen_touch();
    logic [TimeW-1:0] tmo;
    logic [TimeW-1:0] dur;
    logic [TimeW-1:0] t0;
    logic [TimeW-1:0] tl;
    int x;
    int y;
    int s;
    int n;
    int m;
    int i;
    int j;
    tmo = TimeW'(limits.release_timeout);
    s = int'(limits.swipe_px);
    push_poll(t_ms + tmo + 1 + $urandom_range(0, 20), 1'($urandom_range(0, 1)));
    case ($urandom_range(0, 3))
      0: dur = (limits.click_min <= limits.click_max) ?
               $urandom_range(limits.click_min, limits.click_max) : $urandom_range(0, 1000);
      1: dur = TimeW'(limits.hold) + $urandom_range(0, 200);
      2: case ($urandom_range(0, 5))
           0: dur = TimeW'(limits.click_min) - 1;
           1: dur = TimeW'(limits.click_min);
           2: dur = TimeW'(limits.click_max);
           3: dur = TimeW'(limits.click_max) + 1;
           4: dur = TimeW'(limits.hold) - 1;
           default: dur = TimeW'(limits.hold);
         endcase
      default: dur = $urandom_range(0, 3000);
    endcase
    x = $urandom_range(0, MaxCoord);
    y = $urandom_range(0, MaxCoord);
    t0 = t_ms + 1 + $urandom_range(0, 5);
    push_sample(t0, x, y);
    n = $urandom_range(1, 4);
    for (i = 1; i <= n; i++) begin
      tl = t0 + TimeW'((64'(dur) * i) / n);
      case ($urandom_range(0, 4))
        0: ;
        1: begin
          x = clamp_coord(x + int'($urandom_range(0, 2 * s)) - s);
          y = clamp_coord(y + int'($urandom_range(0, 2 * s)) - s);
        end
        2: begin
          x = $urandom_range(0, MaxCoord);
          y = $urandom_range(0, MaxCoord);
        end
        3: begin
          x = $urandom_range(0, 1) ? 0 : MaxCoord;
          y = $urandom_range(0, 1) ? 0 : MaxCoord;
        end
        default: begin
          // just past the threshold on one axis
          if ($urandom_range(0, 1)) x = clamp_coord($urandom_range(0, 1) ? x + s + 1 : x - s - 1);
          else y = clamp_coord($urandom_range(0, 1) ? y + s + 1 : y - s - 1);
        end
      endcase
      push_sample(tl, x, y);
      m = $urandom_range(0, 2);
      for (j = 0; j < m; j++) begin
        if (tmo == 0 || $urandom_range(0, 7) == 0)
          push_poll(tl + tmo, 1'($urandom_range(0, 1)));
        else
          push_poll(tl + $urandom_range(0, tmo - 1), 1'($urandom_range(0, 1)));
      end
    end
    if ($urandom_range(0, 5) != 0)
      push_poll(tl + tmo + 1 + $urandom_range(0, 30), 1'($urandom_range(0, 1)));
  endtask

  task automatic gen_noise();
    logic [TimeW-1:0] now;
    if ($urandom_range(0, 3) == 0) now = $urandom;
    else now = t_ms + $urandom_range(0, 2 * int'(limits.release_timeout) + 2);
    if ($urandom_range(0, 1))
      push_sample(now, $urandom_range(0, MaxCoord), $urandom_range(0, MaxCoord));
    else
      push_poll(now, 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(input int n, input int gap_max, input int wait_max, input bit burst);
    send_gap_max = gap_max;
    recv_wait_max = wait_max;
    phase_items = 0;
    while (phase_items < n) begin
      if ($urandom_range(0, 4) != 0) gen_touch();
      else gen_noise();
    end
    if (burst) long_hold_req++;
    wait_idle();
  endtask

  initial begin : main_sequence
    logic [TimeW-1:0] t;
    limits = {RstReleaseTimeout, RstClickMax, RstClickMin, RstHold, RstSwipePx};
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed touches under the reset thresholds, time wraps early on
    send_gap_max = 3;
    recv_wait_max = 3;
    t = 32'hFFFF_FFF0;
    push_poll(t, 1'b1);
    push_sample(t, 0, MaxCoord);
    push_sample(t + 20, 0, MaxCoord);
    push_poll(t + 120, 1'b0);
    push_poll(t + 121, 1'b1);
    t = t + 1000;
    push_sample(t, MaxCoord, 0);
    push_sample(t + 19, MaxCoord, 0);
    push_poll(t + 120, 1'b0);
    t = t + 1000;
    push_sample(t, 100, 100);
    push_sample(t + 500, 100, 100);
    push_poll(t + 601, 1'b0);
    t = t + 1000;
    push_sample(t, 2000, 2000);
    push_sample(t + 700, 2000, 2000);
    push_poll(t + 799, 1'b0);
    push_poll(t + 750, 1'b0);
    push_sample(t + 750, 2051, 2000);
    push_poll(t + 760, 1'b0);
    push_poll(t + 770, 1'b1);
    push_poll(t + 780, 1'b0);
    push_poll(t + 851, 1'b0);
    t = t + 1000;
    push_sample(t, MaxCoord, MaxCoord);
    push_sample(t + 10, 0, 0);
    push_poll(t + 11, 1'b1);
    push_sample(t + 20, MaxCoord, MaxCoord);
    push_poll(t + 21, 1'b0);
    push_poll(t + 121, 1'b0);
    wait_idle();

    write_all(16'd50, 16'd300, 16'd10, 16'd400, 16'd30);
    run_phase(300, 18, 18, 1'b0);

    write_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    run_phase(100, 18, 0, 1'b0);

    write_all(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(100, 0, 18, 1'b0);

    // back-to-back stream while the result side holds off
    write_all(MsW'($urandom_range(1, 400)), MsW'($urandom_range(100, 1500)),
              MsW'($urandom_range(0, 100)), MsW'($urandom_range(0, 2000)),
              MsW'($urandom_range(0, 300)));
    run_phase(200, 0, 0, 1'b1);

    write_all(MsW'($urandom_range(1, 1000)), MsW'($urandom_range(50, 2000)),
              MsW'($urandom_range(0, 200)), MsW'($urandom_range(0, 3000)),
              {4'($urandom), 12'($urandom_range(0, 200))});
    run_phase(330, 18, 18, 1'b0);

    repeat (10) @(negedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
